[rtl/assert_macros.svh]
// assertion macros used by the rgb_to_hue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

[rtl/rth_pkg.sv]
// shared types and constants of the rgb to hue converter
`default_nettype none

package rth_pkg;

    localparam int ChanW      = 8;   // width of one color channel
    localparam int HueW       = 9;   // width of the hue result
    localparam int SpanW      = 9;   // chroma plus signed channel difference, 0 .. 2*chroma
    localparam int QuotW      = 7;   // rounded sixth-sector quotient, 0 .. 120
    localparam int NumW       = 16;  // rounding numerator 120*span + chroma
    localparam int RecipW     = 25;  // reciprocal of 2*chroma, scaled by 2**RecipShift
    localparam int RecipShift = 25;
    localparam int ProdW      = NumW + RecipW;
    localparam int RecipDepth = 1 << ChanW;

    // sector offsets, each already reduced by the 60 degrees that the chroma bias in span adds
    localparam logic [HueW-1:0] OFF_GRAY  = 9'd0;
    localparam logic [HueW-1:0] OFF_RED   = 9'd300;
    localparam logic [HueW-1:0] OFF_GREEN = 9'd60;
    localparam logic [HueW-1:0] OFF_BLUE  = 9'd180;
    localparam logic [HueW-1:0] HUE_WRAP  = 9'd360;

    localparam logic [NumW-1:0] SLOPE = 16'd120;

    // one classified item between front and back
    typedef struct packed {
        logic [SpanW-1:0] span;
        logic [ChanW-1:0] chroma;
        logic [HueW-1:0]  offset;
    } rth_item_t;

endpackage

`default_nettype wire

[rtl/rth_front.sv]
// front end: accepts pixels, finds max, min, chroma and sector
`default_nettype none

module rth_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [rth_pkg::ChanW-1:0] red,
    input  wire logic [rth_pkg::ChanW-1:0] green,
    input  wire logic [rth_pkg::ChanW-1:0] blue,
    output logic                           item_valid,
    input  wire logic                      item_ready,
    output rth_pkg::rth_item_t             item
);

    logic [rth_pkg::ChanW-1:0] hi;
    logic [rth_pkg::ChanW-1:0] lo;
    logic [rth_pkg::ChanW-1:0] chroma;
    logic [rth_pkg::ChanW+1:0] span_wide;
    rth_pkg::rth_item_t        item_next;
    rth_pkg::rth_item_t        item_reg;
    logic                      valid_reg;

    // max and min of the three channels
    always_comb
    begin
        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue > hi)  hi = blue;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;
        chroma = hi - lo;
    end

    // sector choice, ties go red then green then blue
    always_comb
    begin
        span_wide = '0;
        item_next.offset = rth_pkg::OFF_GRAY;
        priority if (chroma == '0)
        begin
            span_wide = '0;
            item_next.offset = rth_pkg::OFF_GRAY;
        end
        else if (red == hi)
        begin
            span_wide = {2'b00, chroma} + {2'b00, green} - {2'b00, blue};
            item_next.offset = rth_pkg::OFF_RED;
        end
        else if (green == hi)
        begin
            span_wide = {2'b00, chroma} + {2'b00, blue} - {2'b00, red};
            item_next.offset = rth_pkg::OFF_GREEN;
        end
        else
        begin
            span_wide = {2'b00, chroma} + {2'b00, red} - {2'b00, green};
            item_next.offset = rth_pkg::OFF_BLUE;
        end
        item_next.span   = span_wide[rth_pkg::SpanW-1:0];
        item_next.chroma = chroma;
    end

    assign in_ready = !valid_reg || item_ready;

    // holding register toward the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/rth_queue.sv]
// two-entry queue between front and back
`default_nettype none

module rth_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_valid,
    output logic                    wr_ready,
    input  wire rth_pkg::rth_item_t wr_item,
    output logic                    rd_valid,
    input  wire logic               rd_ready,
    output rth_pkg::rth_item_t      rd_item
);

    rth_pkg::rth_item_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

[rtl/rth_back.sv]
// back end: reciprocal divide, rounding and sector offset
`default_nettype none

module rth_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_ready,
    input  wire rth_pkg::rth_item_t       item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [rth_pkg::HueW-1:0]      hue
);

    logic [rth_pkg::RecipW-1:0] recip_tab [rth_pkg::RecipDepth];

    logic                        s1_valid_reg;
    logic [rth_pkg::NumW-1:0]    s1_num_reg;
    logic [rth_pkg::RecipW-1:0]  s1_recip_reg;
    logic [rth_pkg::HueW-1:0]    s1_off_reg;
    logic                        s2_valid_reg;
    logic [rth_pkg::QuotW-1:0]   s2_quot_reg;
    logic [rth_pkg::HueW-1:0]    s2_off_reg;
    logic                        s3_valid_reg;
    logic [rth_pkg::HueW-1:0]    s3_hue_reg;

    logic                        s1_free;
    logic                        s2_free;
    logic                        s3_free;
    logic [rth_pkg::NumW-1:0]    num_next;
    logic [rth_pkg::ProdW-1:0]   prod;
    logic [rth_pkg::HueW-1:0]    sum;
    logic [rth_pkg::HueW-1:0]    hue_next;

    // ceil(2**25 / (2*chroma)); chroma zero only on gray items, whose numerator is zero
    for (genvar i = 0; i < rth_pkg::RecipDepth; i++)
    begin : g_recip
        if (i == 0)
        begin : g_zero
            assign recip_tab[i] = '0;
        end
        else
        begin : g_val
            localparam int RECIP = ((1 << (rth_pkg::RecipShift - 1)) + i - 1) / i;
            assign recip_tab[i] = rth_pkg::RecipW'(RECIP);
        end
    end

    // stage flow: a stage takes new data when it is empty or its successor moves
    assign s3_free    = !s3_valid_reg || out_ready;
    assign s2_free    = !s2_valid_reg || s3_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item_ready = s1_free;

    // rounding numerator 120*span + chroma
    assign num_next = item.span * rth_pkg::SLOPE + rth_pkg::NumW'(item.chroma);

    // quotient by reciprocal multiply, exact for every numerator in range
    assign prod = rth_pkg::ProdW'(s1_num_reg) * rth_pkg::ProdW'(s1_recip_reg);

    // add sector offset and wrap at 360
    always_comb
    begin
        sum = rth_pkg::HueW'(s2_quot_reg) + s2_off_reg;
        if (sum >= rth_pkg::HUE_WRAP)
        begin
            hue_next = sum - rth_pkg::HUE_WRAP;
        end
        else
        begin
            hue_next = sum;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free) s1_valid_reg <= item_valid;
            if (s2_free) s2_valid_reg <= s1_valid_reg;
            if (s3_free) s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_free && item_valid)
        begin
            s1_num_reg   <= num_next;
            s1_recip_reg <= recip_tab[item.chroma];
            s1_off_reg   <= item.offset;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_quot_reg <= prod[rth_pkg::RecipShift +: rth_pkg::QuotW];
            s2_off_reg  <= s1_off_reg;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_hue_reg <= hue_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign hue       = s3_hue_reg;

endmodule

`default_nettype wire

[rtl/rgb_to_hue.sv]
// rgb to hsv hue converter, top level
//
// Takes one 8-bit RGB pixel per item and returns its hue in whole degrees (0..359,
// gray gives 0, ties on the maximum go red, then green, then blue, halves round up).
// One item is accepted every clock while the output is taken; each item passes
// the front register, the queue, then three back stages (numerator and reciprocal
// lookup, 16x25 multiply, offset add and wrap). The front and back are parted
// by a two-entry queue, so each side stalls on its own.
`default_nettype none

module rgb_to_hue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [rth_pkg::ChanW-1:0] red,
    input  wire logic [rth_pkg::ChanW-1:0] green,
    input  wire logic [rth_pkg::ChanW-1:0] blue,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [rth_pkg::HueW-1:0]       hue
);

`include "assert_macros.svh"

    logic               fr_valid;
    logic               fr_ready;
    rth_pkg::rth_item_t fr_item;
    logic               bk_valid;
    logic               bk_ready;
    rth_pkg::rth_item_t bk_item;

    // classification front end
    rth_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    // decoupling queue
    rth_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_item  (bk_item)
    );

    // arithmetic back end
    rth_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (bk_valid),
        .item_ready (bk_ready),
        .item       (bk_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue)
    );

    // checks
    `ASSERT_IMPL(a_hue_range, out_valid, hue < rth_pkg::HUE_WRAP)
    `ASSERT_IMPL(a_back_stall_cause, !bk_ready, out_valid && !out_ready)
    `ASSERT_NEXT(a_front_loads, in_valid && in_ready, fr_valid)
    `ASSERT_IMPL(a_front_stall_cause, !in_ready, fr_valid && !fr_ready)

endmodule

`default_nettype wire

[tb/rgb_to_hue_check.sv]
// checker for the rgb to hue converter: predicts each hue and compares the output items
`default_nettype none

module rgb_to_hue_check (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic [rth_pkg::ChanW-1:0]  red,
    input  wire logic [rth_pkg::ChanW-1:0]  green,
    input  wire logic [rth_pkg::ChanW-1:0]  blue,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [rth_pkg::HueW-1:0]   hue,
    output int                              pending,
    output int                              errors
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [rth_pkg::ChanW-1:0] r;
        logic [rth_pkg::ChanW-1:0] g;
        logic [rth_pkg::ChanW-1:0] b;
        logic [rth_pkg::HueW-1:0]  deg;
    } hue_expect_t;

    hue_expect_t expected_hues[$];
    int          mismatch_count;

    // hue in whole degrees, exact integer math with halves rounded up
    function automatic logic [rth_pkg::HueW-1:0] predict_hue(
        input logic [rth_pkg::ChanW-1:0] r,
        input logic [rth_pkg::ChanW-1:0] g,
        input logic [rth_pkg::ChanW-1:0] b);
        int unsigned rr;
        int unsigned gg;
        int unsigned bb;
        int unsigned hi;
        int unsigned lo;
        int unsigned chroma;
        int unsigned num;
        int unsigned deg;
        rr = 32'(r);
        gg = 32'(g);
        bb = 32'(b);
        hi = rr;
        lo = rr;
        if (gg > hi) hi = gg;
        if (bb > hi) hi = bb;
        if (gg < lo) lo = gg;
        if (bb < lo) lo = bb;
        chroma = hi - lo;
        // gray pixel
        if (chroma == 0)
            return '0;
        // sector numerator, ties on the maximum go red then green then blue
        if (rr == hi)
            num = (gg >= bb) ? 60 * (gg - bb) : 360 * chroma - 60 * (bb - gg);
        else if (gg == hi)
            num = 120 * chroma + 60 * bb - 60 * rr;
        else
            num = 240 * chroma + 60 * rr - 60 * gg;
        deg = (2 * num + chroma) / (2 * chroma);
        // a full turn wraps to zero
        if (deg >= 360)
            deg = 0;
        return deg[rth_pkg::HueW-1:0];
    endfunction

    initial begin
        pending = 0;
        errors = 0;
        mismatch_count = 0;
    end

    // watch both channels at each clock edge
    always @(posedge clk) begin
        hue_expect_t head;
        hue_expect_t item;
        if (rst_n) begin
            // output side: compare against the oldest expectation
            if (out_valid && out_ready) begin
                if (expected_hues.size() == 0) begin
                    $display("%0t: unexpected hue item: expected none, actual %0d", $time, hue);
                    mismatch_count++;
                end
                else begin
                    head = expected_hues.pop_front();
                    if (hue !== head.deg) begin
                        $display("%0t: hue of pixel (%0d,%0d,%0d): expected %0d, actual %0d",
                                 $time, head.r, head.g, head.b, head.deg, hue);
                        mismatch_count++;
                    end
                end
            end
            // input side: queue the predicted hue
            if (in_valid && in_ready) begin
                item.r = red;
                item.g = green;
                item.b = blue;
                item.deg = predict_hue(red, green, blue);
                expected_hues = {expected_hues, item};
            end
        end
        pending <= expected_hues.size();
        errors <= mismatch_count;
    end

endmodule

`default_nettype wire

[tb/rgb_to_hue_test.sv]
// top of the rgb to hue testbench: clock, reset, pixel stimulus, output stalls and verdict
`default_nettype none

module rgb_to_hue_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomPixels = 650;
    localparam int SteadyFrom   = 550;
    localparam int SqueezeAt    = 300;
    localparam int LongStall    = 80;
    localparam int CycleLimit   = 200000;
    localparam int DrainCycles  = 12;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [rth_pkg::ChanW-1:0] red;
    logic [rth_pkg::ChanW-1:0] green;
    logic [rth_pkg::ChanW-1:0] blue;
    logic                      out_valid;
    logic                      out_ready;
    logic [rth_pkg::HueW-1:0]  hue;
    int                        pending;
    int                        errors;
    int                        cycles;

    // steady and squeeze are shared by the pixel sender and the output stall process
    bit steady;
    bit squeeze;
    bit long_done;

    rgb_to_hue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hue       (hue)
    );

    rgb_to_hue_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hue       (hue),
        .pending   (pending),
        .errors    (errors)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // offer one pixel, hold it until taken, then maybe idle a burst
    task automatic send_pixel(input logic [rth_pkg::ChanW-1:0] r,
                              input logic [rth_pkg::ChanW-1:0] g,
                              input logic [rth_pkg::ChanW-1:0] b);
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        do @(posedge clk); while (!in_ready);
        if (!steady && !squeeze && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // random pixel, shaped toward grays, ties, small chroma, wrap point, sector edges
    task automatic send_random_pixel();
        logic [rth_pkg::ChanW-1:0] m;
        logic [rth_pkg::ChanW-1:0] v;
        logic [rth_pkg::ChanW-1:0] d;
        logic [rth_pkg::ChanW-1:0] e;
        logic [rth_pkg::ChanW:0]   w;
        int unsigned               kind;
        kind = $urandom_range(0, 19);
        m = rth_pkg::ChanW'($urandom_range(0, 255));
        v = rth_pkg::ChanW'($urandom_range(0, 32'(m)));
        d = rth_pkg::ChanW'($urandom_range(0, 3));
        e = rth_pkg::ChanW'($urandom_range(0, 1));
        w = {1'b0, v} + {1'b0, d} + 9'd1;
        if (kind < 8) begin
            send_pixel(rth_pkg::ChanW'($urandom_range(0, 255)),
                       rth_pkg::ChanW'($urandom_range(0, 255)),
                       rth_pkg::ChanW'($urandom_range(0, 255)));
        end
        else if (kind < 9) begin
            // gray
            send_pixel(m, m, m);
        end
        else if (kind < 12) begin
            // two channels share the maximum
            case ($urandom_range(0, 2))
                0: send_pixel(m, m, v);
                1: send_pixel(m, v, m);
                default: send_pixel(v, m, m);
            endcase
        end
        else if (kind < 15) begin
            // chroma of a few counts
            send_pixel(m, (m > d) ? m - d : m, (m > 1) ? m - e : m);
        end
        else if (kind < 17) begin
            // red maximum with blue just above green, close to a full turn
            send_pixel(m, v, (w <= {1'b0, m}) ? w[rth_pkg::ChanW-1:0] : m);
        end
        else begin
            // sector edges: one channel at the floor, one at the top
            case ($urandom_range(0, 2))
                0: send_pixel(m, v, 8'd0);
                1: send_pixel(8'd0, m, v);
                default: send_pixel(v, 8'd0, m);
            endcase
        end
    endtask

    // pixel stimulus and verdict
    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        red <= '0;
        green <= '0;
        blue <= '0;
        steady = 1'b0;
        squeeze = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels: extremes, each sector, ties, wrap and half rounding
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd200, 8'd200);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd2);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd1);
        send_pixel(8'd120, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd120, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd120);
        send_pixel(8'd85, 8'd170, 8'd85);
        send_pixel(8'd170, 8'd85, 8'd170);
        send_pixel(8'h55, 8'hAA, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'h00);
        send_pixel(8'd254, 8'd255, 8'd254);
        send_pixel(8'd3, 8'd2, 8'd5);

        // random pixels, with one long output hold-off and a quiet tail
        for (int i = 0; i < RandomPixels; i++) begin
            if (i == SqueezeAt)
                squeeze = 1'b1;
            if (i == SteadyFrom)
                steady = 1'b1;
            send_random_pixel();
        end
        in_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // output stalls: random bursts, one long hold-off, none in the tail
    initial begin
        int unsigned stall_left;
        out_ready <= 1'b0;
        stall_left = 0;
        long_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (squeeze && !long_done) begin
                stall_left = LongStall;
                long_done = 1'b1;
            end
            else if (stall_left == 0 && !steady && !squeeze && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ready <= 1'b1;
                if (long_done)
                    squeeze = 1'b0;
            end
        end
    end

    // cycle limit
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

`default_nettype wire
